// ===== rtl/core/mrf_pkg.sv =====
// shared types, constants and the crc byte update for the modbus rtu request framer
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package mrf_pkg;

	// crc-16/modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// modbus function codes
	localparam logic [7:0] FN_READ_HOLD  = 8'h03;
	localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
	localparam logic [7:0] FN_WRITE_MANY = 8'h10;

	// action codes of an input transaction
	localparam logic [1:0] ACT_READ_HOLD = 2'd0;
	localparam logic [1:0] ACT_WRITE_ONE = 2'd1;
	localparam logic [1:0] ACT_MANY_HDR  = 2'd2;
	localparam logic [1:0] ACT_MANY_VAL  = 2'd3;

	// byte positions within a frame segment
	localparam logic [3:0] IDX_SLAVE  = 4'd0;
	localparam logic [3:0] IDX_FN     = 4'd1;
	localparam logic [3:0] IDX_AHI    = 4'd2;
	localparam logic [3:0] IDX_ALO    = 4'd3;
	localparam logic [3:0] IDX_OHI    = 4'd4;
	localparam logic [3:0] IDX_OLO    = 4'd5;
	localparam logic [3:0] IDX_BC     = 4'd6;
	localparam logic [3:0] IDX_CRC_LO = 4'd7;
	localparam logic [3:0] IDX_CRC_HI = 4'd8;

	// depth of the command queue between front and back
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  slave_address;
		logic [15:0] register_address;
		logic [15:0] operand;
		logic        last_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        new_frame;
		logic [7:0]  fn_code;
		logic [7:0]  slave;
		logic [15:0] reg_addr;
		logic [15:0] operand;
		logic [3:0]  first_idx;
		logic        has_bc;
		logic        has_crc;
	} cmd_t;

	// back status seen by the top level
	typedef struct packed {
		logic        busy;
		logic        emit_end;
		logic [15:0] crc;
	} back_stat_t;

	// one byte through the reflected crc, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrf_front.sv =====
// front part: accepts request transactions and classifies them into commands
// depends on mrf_pkg
`default_nettype none

module mrf_front (
	input  wire logic             push,
	input  wire logic             full,
	input  wire mrf_pkg::in_item_t request,
	output logic                  wr_en,
	output mrf_pkg::cmd_t         cmd
);

	// accept when the queue has room
	assign wr_en = push && !full;

	// classify by action
	always_comb begin
		cmd.new_frame = (request.action != mrf_pkg::ACT_MANY_VAL);
		cmd.slave     = request.slave_address;
		cmd.reg_addr  = request.register_address;
		cmd.operand   = request.operand;
		cmd.has_bc    = (request.action == mrf_pkg::ACT_MANY_HDR);
		cmd.first_idx = mrf_pkg::IDX_SLAVE;
		cmd.fn_code   = mrf_pkg::FN_WRITE_MANY;
		cmd.has_crc   = 1'b1;
		case (request.action)
			mrf_pkg::ACT_READ_HOLD: begin
				cmd.fn_code = mrf_pkg::FN_READ_HOLD;
			end
			mrf_pkg::ACT_WRITE_ONE: begin
				cmd.fn_code = mrf_pkg::FN_WRITE_ONE;
			end
			mrf_pkg::ACT_MANY_HDR: begin
				cmd.has_crc = (request.operand == 16'd0);
			end
			mrf_pkg::ACT_MANY_VAL: begin
				cmd.first_idx = mrf_pkg::IDX_OHI;
				cmd.has_crc   = request.last_value;
			end
			default: begin
				cmd.has_crc = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_cmd_fifo.sv =====
// short command queue between front and back
// depends on mrf_pkg
`default_nettype none

module mrf_cmd_fifo #(
	parameter int FifoDepth = mrf_pkg::FIFO_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire mrf_pkg::cmd_t wr_data,
	input  wire logic          rd_en,
	output mrf_pkg::cmd_t      rd_data,
	output logic               full,
	output logic               empty
);

	localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
	localparam int CntW = $clog2(FifoDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

	mrf_pkg::cmd_t   mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntFull);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_back.sv =====
// back part: steps through the bytes of each command, runs the crc, holds the output register
// depends on mrf_pkg
`default_nettype none

module mrf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mrf_pkg::cmd_t head,
	input  wire logic          head_empty,
	output logic               head_pop,
	input  wire logic          pop,
	output logic               empty,
	output mrf_pkg::out_item_t frame,
	output mrf_pkg::back_stat_t stat
);

	logic               busy_q;
	mrf_pkg::cmd_t      cmd_q;
	logic [3:0]         idx_q;
	logic [15:0]        crc_q;
	logic               out_valid_q;
	mrf_pkg::out_item_t out_q;

	logic       out_room;
	logic       emit;
	logic       last_byte;
	logic       done;
	logic       take;
	logic [7:0] cur_byte;
	logic [3:0] idx_next;

	assign out_room = !out_valid_q || pop;
	assign emit     = busy_q && out_room;

	// byte select
	always_comb begin
		case (idx_q)
			mrf_pkg::IDX_SLAVE:  cur_byte = cmd_q.slave;
			mrf_pkg::IDX_FN:     cur_byte = cmd_q.fn_code;
			mrf_pkg::IDX_AHI:    cur_byte = cmd_q.reg_addr[15:8];
			mrf_pkg::IDX_ALO:    cur_byte = cmd_q.reg_addr[7:0];
			mrf_pkg::IDX_OHI:    cur_byte = cmd_q.operand[15:8];
			mrf_pkg::IDX_OLO:    cur_byte = cmd_q.operand[7:0];
			mrf_pkg::IDX_BC:     cur_byte = {cmd_q.operand[6:0], 1'b0};
			mrf_pkg::IDX_CRC_LO: cur_byte = crc_q[7:0];
			mrf_pkg::IDX_CRC_HI: cur_byte = crc_q[15:8];
			default:             cur_byte = 8'h00;
		endcase
	end

	// end of segment and next position
	always_comb begin
		last_byte = (idx_q == mrf_pkg::IDX_CRC_HI)
			|| (idx_q == mrf_pkg::IDX_OLO && !cmd_q.has_bc && !cmd_q.has_crc)
			|| (idx_q == mrf_pkg::IDX_BC && !cmd_q.has_crc);
		case (idx_q)
			mrf_pkg::IDX_OLO: idx_next = cmd_q.has_bc ? mrf_pkg::IDX_BC : mrf_pkg::IDX_CRC_LO;
			default:          idx_next = idx_q + 4'd1;
		endcase
	end

	assign done     = emit && last_byte;
	assign take     = !head_empty && (!busy_q || done);
	assign head_pop = take;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= mrf_pkg::IDX_SLAVE;
			crc_q  <= mrf_pkg::CRC_INIT;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= head.first_idx;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_next;
			end
			// crc: a new frame restarts it, a closed frame returns it to its initial value
			if (take && head.new_frame) begin
				crc_q <= mrf_pkg::CRC_INIT;
			end else if (emit) begin
				if (idx_q == mrf_pkg::IDX_CRC_HI) begin
					crc_q <= mrf_pkg::CRC_INIT;
				end else if (idx_q != mrf_pkg::IDX_CRC_LO) begin
					crc_q <= mrf_pkg::crc_byte(crc_q, cur_byte);
				end
			end
		end
	end

	// command hold register
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= head;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.frame_byte <= cur_byte;
			out_q.frame_end  <= (idx_q == mrf_pkg::IDX_CRC_HI);
		end
	end

	assign empty         = !out_valid_q;
	assign frame         = out_q;
	assign stat.busy     = busy_q;
	assign stat.emit_end = emit && (idx_q == mrf_pkg::IDX_CRC_HI);
	assign stat.crc      = crc_q;

endmodule

`default_nettype wire

// ===== rtl/core/modbus_rtu_request_framer.sv =====
// modbus rtu request framer: one request transaction in, two to nine frame bytes out
// path: queue, then the back's command register, then the output register for each byte
// throughput: one frame byte per cycle while the output register is free or being popped,
// set by the byte sequencer in the back; the next request follows without a gap
// reset: asynchronous, active low; clears the queue, the output register and the crc to 0xffff
`default_nettype none

module modbus_rtu_request_framer #(
	parameter int FifoDepth = mrf_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire mrf_pkg::in_item_t request,
	output logic                   empty,
	input  wire logic              pop,
	output mrf_pkg::out_item_t     frame
);

	logic                wr_en;
	mrf_pkg::cmd_t       wr_cmd;
	mrf_pkg::cmd_t       head;
	logic                head_empty;
	logic                head_pop;
	mrf_pkg::back_stat_t stat;

	// classify
	mrf_front u_front (
		.push    (push),
		.full    (full),
		.request (request),
		.wr_en   (wr_en),
		.cmd     (wr_cmd)
	);

	// command queue
	mrf_cmd_fifo #(
		.FifoDepth (FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_cmd),
		.rd_en   (head_pop),
		.rd_data (head),
		.full    (full),
		.empty   (head_empty)
	);

	// byte sequencer and crc
	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.frame      (frame),
		.stat       (stat)
	);

`ifndef ASSERT_OFF
	// an accepted request is held in the queue at the next edge
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !head_empty)
		else $error("accepted request not in queue");

	// an idle back picks up a waiting command
	a_idle_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy && !head_empty |=> stat.busy)
		else $error("idle back did not take waiting command");

	// closing a frame returns the crc to its initial value
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit_end |=> stat.crc == mrf_pkg::CRC_INIT)
		else $error("crc not restarted after frame end");
`endif

endmodule

`default_nettype wire
